>>> rtl/core/cqs_pkg.sv
// shared types and constants for the column quartile statistics unit
`timescale 1ns / 1ps

package cqs_pkg;

    localparam int MAX_SAMPLES_DEF = 64;
    localparam int SAMPLE_W        = 32;
    localparam int VAL_W           = 31;
    localparam int OUT_DATA_W      = 160;
    localparam int OUT_USER_W      = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_PLACE,
        ST_STAT_RD,
        ST_STAT_CAP,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        SEL_MIN,
        SEL_Q1A,
        SEL_Q1B,
        SEL_MED,
        SEL_Q3A,
        SEL_Q3B,
        SEL_MAX
    } t_sel;

    typedef struct packed {
        logic q1;
        logic q3;
    } t_pair_flags;

endpackage

>>> rtl/core/cqs_pos.sv
// sorted-store positions of the summary values above the minimum, and the quartile pair flags, for a given kept count
`timescale 1ns / 1ps

module cqs_pos
    import cqs_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    localparam int CW = $clog2(MAX_SAMPLES + 1),
    localparam int AW = $clog2(MAX_SAMPLES)
) (
    input  logic [CW-1:0] i_count,
    output logic [AW-1:0] o_q1_idx,
    output logic [AW-1:0] o_med_idx,
    output logic [AW-1:0] o_q3_idx,
    output logic [AW-1:0] o_max_idx,
    output t_pair_flags   o_pair
);

    logic [CW-1:0] w_mp;
    logic [CW-1:0] w_rest;
    logic [CW-1:0] w_q1;
    logic [CW-1:0] w_q3;
    logic [CW-1:0] w_last;

    always_comb begin
        w_mp   = i_count >> 1;
        w_rest = i_count - w_mp - CW'(1);
        w_q1   = w_mp >> 1;
        w_q3   = w_mp + (w_rest >> 1);
        w_last = i_count - CW'(1);
    end

    assign o_q1_idx  = w_q1[AW-1:0];
    assign o_med_idx = w_mp[AW-1:0];
    assign o_q3_idx  = w_q3[AW-1:0];
    assign o_max_idx = w_last[AW-1:0];
    assign o_pair.q1 = w_mp[0];
    assign o_pair.q3 = w_rest[0];

endmodule

>>> rtl/core/column_quartile_statistics_unit.sv
// column quartile statistics: insertion sort into a store, five-number summary at column end
// a kept sample runs c compares through the store read port, then a place step: c is none on an
// empty column, else min(s + 1, kept) with s = stored entries larger than it; a missing or
// dropped sample is taken without store access; a marked last sample adds store reads of 7
// positions, then loads the output register, which waits while the previous result
// word is not taken; an empty column goes straight to the output register
// sync reset (i_rst_n low) empties the column; store contents need no clearing pass
`timescale 1ns / 1ps

module column_quartile_statistics_unit
    import cqs_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [SAMPLE_W-1:0]   i_s_axis_tdata,  // sample[31:0]
    input  logic                  i_s_axis_tlast,  // last_sample
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // minimum[30:0], first_quartile[61:31], median_value[92:62],
    // third_quartile[123:93], maximum[154:124], zero[159:155]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [OUT_USER_W-1:0] o_m_axis_tuser   // empty_set[0], overflowed[1]
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int PAD_W = OUT_DATA_W - 5 * VAL_W;

    t_state r_state, n_state;
    t_sel   r_sel, n_sel;
    logic [CW-1:0]    r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [CW-1:0]    r_pos, n_pos;
    logic [VAL_W-1:0] r_val, n_val;
    logic             r_last, n_last;
    logic [VAL_W-1:0] r_acc, n_acc;
    logic [VAL_W-1:0] r_min, n_min;
    logic [VAL_W-1:0] r_q1, n_q1;
    logic [VAL_W-1:0] r_med, n_med;
    logic [VAL_W-1:0] r_q3, n_q3;
    logic [VAL_W-1:0] r_max, n_max;
    logic [VAL_W-1:0] r_rdata;
    logic [VAL_W-1:0] r_mem [MAX_SAMPLES];

    logic             r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_o_min, n_o_min;
    logic [VAL_W-1:0] r_o_q1, n_o_q1;
    logic [VAL_W-1:0] r_o_med, n_o_med;
    logic [VAL_W-1:0] r_o_q3, n_o_q3;
    logic [VAL_W-1:0] r_o_max, n_o_max;
    logic             r_o_empty, n_o_empty;
    logic             r_o_ovf, n_o_ovf;

    logic             w_accept;
    logic             w_keep;
    logic             w_insert;
    logic             w_shift;
    logic             w_load;
    logic [VAL_W:0]   w_sum;
    logic [VAL_W-1:0] w_mean;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [VAL_W-1:0] w_wdata;
    logic [AW-1:0]    w_raddr;

    logic [AW-1:0] w_q1_idx, w_med_idx, w_q3_idx, w_max_idx;
    t_pair_flags   w_pair;

    cqs_pos #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_pos (
        .i_count  (r_count),
        .o_q1_idx (w_q1_idx),
        .o_med_idx(w_med_idx),
        .o_q3_idx (w_q3_idx),
        .o_max_idx(w_max_idx),
        .o_pair   (w_pair)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_keep   = !i_s_axis_tdata[SAMPLE_W-1];
    assign w_insert = w_keep && (r_count != CW'(MAX_SAMPLES));
    // store entry below the insertion point is larger: move it up
    assign w_shift  = (r_rdata > r_val);
    assign w_load   = !r_out_valid || i_m_axis_tready;
    assign w_sum    = {1'b0, r_acc} + {1'b0, r_rdata};
    assign w_mean   = w_sum[VAL_W:1];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_insert) begin
                        n_state = (r_count == '0) ? ST_PLACE : ST_RD;
                    end else if (i_s_axis_tlast) begin
                        n_state = (r_count == '0) ? ST_EMIT : ST_STAT_RD;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (w_shift && (r_pos != CW'(1))) begin
                    n_state = ST_RD;
                end else begin
                    n_state = ST_PLACE;
                end
            end
            ST_PLACE: begin
                n_state = r_last ? ST_STAT_RD : ST_IDLE;
            end
            ST_STAT_RD: begin
                n_state = ST_STAT_CAP;
            end
            ST_STAT_CAP: begin
                n_state = (r_sel == SEL_MAX) ? ST_EMIT : ST_STAT_RD;
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and store control
    always_comb begin
        n_sel   = r_sel;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_pos   = r_pos;
        n_val   = r_val;
        n_last  = r_last;
        n_acc   = r_acc;
        n_min   = r_min;
        n_q1    = r_q1;
        n_med   = r_med;
        n_q3    = r_q3;
        n_max   = r_max;
        w_we    = 1'b0;
        w_waddr = r_pos[AW-1:0];
        w_wdata = r_val;
        w_raddr = '0;

        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_o_min     = r_o_min;
        n_o_q1      = r_o_q1;
        n_o_med     = r_o_med;
        n_o_q3      = r_o_q3;
        n_o_max     = r_o_max;
        n_o_empty   = r_o_empty;
        n_o_ovf     = r_o_ovf;

        case (r_state)
            ST_IDLE: begin
                n_sel = SEL_MIN;
                if (w_accept) begin
                    n_last = i_s_axis_tlast;
                    n_val  = i_s_axis_tdata[VAL_W-1:0];
                    n_pos  = r_count;
                    if (w_keep && !w_insert) begin
                        n_ovf = 1'b1;
                    end
                end
            end
            ST_RD: begin
                w_raddr = AW'(r_pos - CW'(1));
            end
            ST_CMP: begin
                if (w_shift) begin
                    w_we    = 1'b1;
                    w_wdata = r_rdata;
                    n_pos   = r_pos - CW'(1);
                end
            end
            ST_PLACE: begin
                w_we    = 1'b1;
                n_count = r_count + CW'(1);
            end
            ST_STAT_RD: begin
                case (r_sel)
                    SEL_MIN: w_raddr = '0;
                    SEL_Q1A: w_raddr = w_q1_idx;
                    SEL_Q1B: w_raddr = w_q1_idx + AW'(1);
                    SEL_MED: w_raddr = w_med_idx;
                    SEL_Q3A: w_raddr = w_q3_idx;
                    SEL_Q3B: w_raddr = w_q3_idx + AW'(1);
                    SEL_MAX: w_raddr = w_max_idx;
                    default: w_raddr = '0;
                endcase
            end
            ST_STAT_CAP: begin
                n_sel = t_sel'(r_sel + 3'd1);
                case (r_sel)
                    SEL_MIN: n_min = r_rdata;
                    SEL_Q1A: n_acc = r_rdata;
                    SEL_Q1B: n_q1  = w_pair.q1 ? w_mean : r_acc;
                    SEL_MED: n_med = r_rdata;
                    SEL_Q3A: n_acc = r_rdata;
                    SEL_Q3B: n_q3  = w_pair.q3 ? w_mean : r_acc;
                    SEL_MAX: n_max = r_rdata;
                    default: n_acc = r_acc;
                endcase
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_o_empty   = (r_count == '0);
                    n_o_ovf     = (r_count != '0) && r_ovf;
                    n_o_min     = (r_count == '0) ? '0 : r_min;
                    n_o_q1      = (r_count == '0) ? '0 : r_q1;
                    n_o_med     = (r_count == '0) ? '0 : r_med;
                    n_o_q3      = (r_count == '0) ? '0 : r_q3;
                    n_o_max     = (r_count == '0) ? '0 : r_max;
                    n_count     = '0;
                    n_ovf       = 1'b0;
                end
            end
            default: begin
                n_sel = SEL_MIN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sel       <= SEL_MIN;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_acc     <= n_acc;
        r_min     <= n_min;
        r_q1      <= n_q1;
        r_med     <= n_med;
        r_q3      <= n_q3;
        r_max     <= n_max;
        r_o_min   <= n_o_min;
        r_o_q1    <= n_o_q1;
        r_o_med   <= n_o_med;
        r_o_q3    <= n_o_q3;
        r_o_max   <= n_o_max;
        r_o_empty <= n_o_empty;
        r_o_ovf   <= n_o_ovf;
    end

    // sorted store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {PAD_W'(0), r_o_max, r_o_q3, r_o_med, r_o_q1, r_o_min};
    assign o_m_axis_tuser  = {r_o_ovf, r_o_empty};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SAMPLES))
        else $error("kept count beyond store depth");

    a_cmp_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (r_pos != '0))
        else $error("compare step at store bottom");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && w_load) |=> (r_count == '0 && !r_ovf && o_m_axis_tvalid))
        else $error("column not cleared after result load");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0 && !o_m_axis_tuser[1]))
        else $error("empty column with nonzero result");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_keep && r_count == CW'(MAX_SAMPLES)) |=> r_ovf)
        else $error("overflow not recorded");

endmodule

>>> tb/column_quartile_statistics_unit_tb.sv
// testbench for the column quartile statistics unit: directed and random columns against a sorted predictor
`timescale 1ns / 1ps

module column_quartile_statistics_unit_tb;
    import cqs_pkg::*;

    localparam int WORD_TARGET = 900;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } sample_word_t;

    typedef struct packed {
        logic [VAL_W-1:0] minimum;
        logic [VAL_W-1:0] first_quartile;
        logic [VAL_W-1:0] median_value;
        logic [VAL_W-1:0] third_quartile;
        logic [VAL_W-1:0] maximum;
        logic             empty_set;
        logic             overflowed;
    } col_summary_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [SAMPLE_W-1:0]   i_s_axis_tdata = '0;   // sample[31:0]
    logic                  i_s_axis_tlast = 1'b0;  // last_sample
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // minimum[30:0], first_quartile[61:31], median_value[92:62],
    // third_quartile[123:93], maximum[154:124], zero[159:155]
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [OUT_USER_W-1:0] o_m_axis_tuser;         // empty_set[0], overflowed[1]

    sample_word_t     pending_words[$];
    col_summary_t     expected_summaries[$];
    logic [VAL_W-1:0] sorted_column[$];
    bit               column_overflow = 1'b0;
    int               mismatch_count = 0;
    int               words_sent = 0;
    int               results_taken = 0;
    int               send_gap = 0;
    int               recv_stall = 0;
    int               hold_left = 0;

    column_quartile_statistics_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // element at pos, or the truncated mean of it and its upper neighbor
    function automatic logic [VAL_W-1:0] quartile_at(int pos, bit pair);
        logic [VAL_W:0] sum;
        if (!pair) return sorted_column[pos];
        sum = {1'b0, sorted_column[pos]} + {1'b0, sorted_column[pos + 1]};
        return sum[VAL_W:1];
    endfunction

    function automatic void column_absorb(logic [SAMPLE_W-1:0] sample, logic last);
        col_summary_t s;
        int           pos;
        int           n;
        int           mid;
        int           upper;
        if (!sample[SAMPLE_W-1]) begin
            if (sorted_column.size() < MAX_SAMPLES_DEF) begin
                pos = 0;
                while (pos < sorted_column.size() && sorted_column[pos] <= sample[VAL_W-1:0])
                    pos++;
                sorted_column.insert(pos, sample[VAL_W-1:0]);
            end else begin
                column_overflow = 1'b1;
            end
        end
        if (last) begin
            s = '0;
            n = sorted_column.size();
            if (n == 0) begin
                s.empty_set = 1'b1;
            end else begin
                mid = n / 2;
                upper = n - mid - 1;
                s.minimum        = sorted_column[0];
                s.first_quartile = quartile_at(mid / 2, bit'(mid % 2));
                s.median_value   = sorted_column[mid];
                s.third_quartile = quartile_at(mid + upper / 2, bit'(upper % 2));
                s.maximum        = sorted_column[n - 1];
                s.overflowed     = column_overflow;
            end
            expected_summaries.insert(expected_summaries.size(), s);
            sorted_column.delete();
            column_overflow = 1'b0;
        end
    endfunction

    function automatic int pick_gap(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return $urandom | 32'h8000_0000;
        if (r < 20) begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0001;
                default: return 32'h7FFF_FFFE;
            endcase
        end
        if (r < 38) return $urandom_range(0, 15);
        if (r < 50 && !prev[SAMPLE_W-1]) return prev;
        return $urandom & 32'h7FFF_FFFF;
    endfunction

    function automatic void check_field(string field, logic [VAL_W-1:0] want,
                                        logic [VAL_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic queue_word(logic [SAMPLE_W-1:0] sample, logic last);
        sample_word_t w;
        w.sample = sample;
        w.last   = last;
        pending_words.insert(pending_words.size(), w);
    endtask

    // sender
    always @(posedge i_clk) begin
        sample_word_t w;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            i_s_axis_tlast  <= 1'b0;
            send_gap        <= 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                column_absorb(i_s_axis_tdata, i_s_axis_tlast);
                words_sent++;
            end
            if (i_s_axis_tvalid && !o_s_axis_tready) begin
                // word still waiting, keep it on the bus
            end else if (send_gap > 0) begin
                send_gap        <= send_gap - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                w = pending_words.pop_front();
                i_s_axis_tdata  <= w.sample;
                i_s_axis_tlast  <= w.last;
                i_s_axis_tvalid <= 1'b1;
                send_gap        <= pick_gap((words_sent / 128) % 4 == 3);
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with two long hold-offs so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            recv_stall      <= 0;
            hold_left       <= 0;
        end else if (hold_left > 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (o_m_axis_tvalid === 1'b1 && i_m_axis_tready
                     && (results_taken == 4 || results_taken == 40)) begin
            hold_left       <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall      <= recv_stall - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            recv_stall      <= pick_gap((results_taken / 16) % 4 == 2);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        col_summary_t want;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            results_taken <= results_taken + 1;
            if (expected_summaries.size() == 0) begin
                $display("%0t ns: result word with nothing expected, actual tdata %h tuser %h",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
                mismatch_count++;
            end else begin
                want = expected_summaries.pop_front();
                check_field("minimum", want.minimum, o_m_axis_tdata[0*VAL_W +: VAL_W]);
                check_field("first_quartile", want.first_quartile,
                            o_m_axis_tdata[1*VAL_W +: VAL_W]);
                check_field("median_value", want.median_value,
                            o_m_axis_tdata[2*VAL_W +: VAL_W]);
                check_field("third_quartile", want.third_quartile,
                            o_m_axis_tdata[3*VAL_W +: VAL_W]);
                check_field("maximum", want.maximum, o_m_axis_tdata[4*VAL_W +: VAL_W]);
                check_field("pad", '0, VAL_W'(o_m_axis_tdata[OUT_DATA_W-1:5*VAL_W]));
                check_field("empty_set", VAL_W'(want.empty_set), VAL_W'(o_m_axis_tuser[0]));
                check_field("overflowed", VAL_W'(want.overflowed), VAL_W'(o_m_axis_tuser[1]));
            end
        end
    end

    initial begin
        int               word_total;
        int               len;
        int               r;
        logic [SAMPLE_W-1:0] v;
        logic [SAMPLE_W-1:0] prev;

        // missing final sample on an empty column, both sign extremes
        queue_word(32'hFFFF_FFFF, 1'b1);
        queue_word(32'h8000_0000, 1'b1);
        // single-sample columns at the value extremes
        queue_word(32'h0000_0000, 1'b1);
        queue_word(32'h7FFF_FFFF, 1'b1);
        // pair mean at the top of the range
        queue_word(32'h7FFF_FFFF, 1'b0);
        queue_word(32'h7FFF_FFFF, 1'b1);
        // three kept, missing final sample still closes the column
        queue_word(32'd5, 1'b0);
        queue_word(32'd3, 1'b0);
        queue_word(32'd9, 1'b0);
        queue_word(32'hFFFF_FFFB, 1'b1);
        // descending input with an odd sum in the third-quartile mean, then a mixed-order column
        queue_word(32'd4, 1'b0);
        queue_word(32'd3, 1'b0);
        queue_word(32'd2, 1'b0);
        queue_word(32'd1, 1'b1);
        queue_word(32'h7FFF_FFFF, 1'b0);
        queue_word(32'd1, 1'b0);
        queue_word(32'h0001_0000, 1'b0);
        queue_word(32'h7FFF_FFFE, 1'b0);
        queue_word(32'd3, 1'b1);

        word_total = pending_words.size();
        prev = '0;
        while (word_total < WORD_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                len = $urandom_range(1, 4);
            end else if (r < 10) begin
                len = $urandom_range(MAX_SAMPLES_DEF + 1, MAX_SAMPLES_DEF + 6);
            end else begin
                r = $urandom_range(0, 99);
                len = r < 50 ? $urandom_range(1, 6)
                    : r < 85 ? $urandom_range(7, 24) : $urandom_range(25, MAX_SAMPLES_DEF);
                r = 99;
            end
            for (int i = 0; i < len; i++) begin
                if (r < 6) begin
                    v = $urandom | 32'h8000_0000;
                end else begin
                    v = pick_sample(prev);
                    // overflow columns keep all but maybe the closing sample
                    if (r < 10 && (i < len - 1 || $urandom_range(0, 1) == 0))
                        v[SAMPLE_W-1] = 1'b0;
                end
                queue_word(v, i == len - 1);
                word_total++;
                prev = v;
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (expected_summaries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("column_quartile_statistics_unit test passed");
        end else begin
            $display("column_quartile_statistics_unit test failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("column_quartile_statistics_unit test failed");
        $finish;
    end

endmodule
